// ===== rtl/core/sjvr_pkg.sv =====
// Shared types, widths, codes and reset values of the six-axis jog velocity ramp.
package sjvr_pkg;

	localparam int AXES      = 6;
	localparam int MAX_AXES  = 6;
	localparam int SPEED_W   = 16;
	localparam int LIMIT_W   = 15;
	localparam int STEP_W    = 15;
	localparam int HOLD_W    = 10;
	localparam int KEY_W     = 8;
	localparam int JOG_W     = 2 * MAX_AXES;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;
	localparam int CALC_W    = SPEED_W + 2;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [KEY_W-1:0] KEY_LOWER   = 8'h61;
	localparam logic [KEY_W-1:0] KEY_DEFAULT = 8'h73;
	localparam logic [KEY_W-1:0] KEY_RAISE   = 8'h64;

	localparam logic [STEP_W-1:0]  RST_ACCEL   = 15'd1287;
	localparam logic [STEP_W-1:0]  RST_DECEL   = 15'd129;
	localparam logic [HOLD_W-1:0]  RST_HOLD    = 10'd100;
	localparam logic [LIMIT_W-1:0] RST_DEFAULT = 15'd12868;
	localparam logic [STEP_W-1:0]  RST_STEP    = 15'd410;
	localparam logic [LIMIT_W-1:0] RST_FLOOR   = 15'd410;
	localparam logic [LIMIT_W-1:0] RST_CEILING = 15'd25326;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 15'h7FFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL   = 3'd0,
		REG_DECEL   = 3'd1,
		REG_HOLD    = 3'd2,
		REG_DEFAULT = 3'd3,
		REG_STEP    = 3'd4,
		REG_FLOOR   = 3'd5,
		REG_CEILING = 3'd6
	} reg_idx_t;

	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef struct packed {
		logic [STEP_W-1:0]  accel;
		logic [STEP_W-1:0]  decel;
		logic [HOLD_W-1:0]  hold_ticks;
		logic [LIMIT_W-1:0] vmax;
	} ramp_cfg_t;

	typedef struct packed {
		logic [HOLD_W-1:0] count;
		logic [1:0]        pair;
		speed_t            speed;
	} axis_state_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] bit_idx;
	} jog_key_t;

	function automatic jog_key_t jog_decode(input logic [KEY_W-1:0] key);
		jog_key_t r;
		r.hit     = 1'b1;
		r.bit_idx = 4'd0;
		case (key)
			8'h31:   r.bit_idx = 4'd0;
			8'h32:   r.bit_idx = 4'd1;
			8'h33:   r.bit_idx = 4'd2;
			8'h34:   r.bit_idx = 4'd3;
			8'h35:   r.bit_idx = 4'd4;
			8'h36:   r.bit_idx = 4'd5;
			8'h37:   r.bit_idx = 4'd6;
			8'h38:   r.bit_idx = 4'd7;
			8'h39:   r.bit_idx = 4'd8;
			8'h30:   r.bit_idx = 4'd9;
			8'h2D:   r.bit_idx = 4'd10;
			8'h3D:   r.bit_idx = 4'd11;
			default: r.hit     = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/sjvr_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface sjvr_in_if import sjvr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [KEY_W-1:0] key_code;
	modport source(output valid, op, key_code, input ready);
	modport sink(input valid, op, key_code, output ready);
endinterface

interface sjvr_out_if import sjvr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed_axis0;
	logic [SPEED_W-1:0] speed_axis1;
	logic [SPEED_W-1:0] speed_axis2;
	logic [SPEED_W-1:0] speed_axis3;
	logic [SPEED_W-1:0] speed_axis4;
	logic [SPEED_W-1:0] speed_axis5;
	logic [LIMIT_W-1:0] speed_limit_now;
	logic [JOG_W-1:0]   jog_bits;
	modport source(output valid, speed_axis0, speed_axis1, speed_axis2, speed_axis3,
		speed_axis4, speed_axis5, speed_limit_now, jog_bits, input ready);
	modport sink(input valid, speed_axis0, speed_axis1, speed_axis2, speed_axis3,
		speed_axis4, speed_axis5, speed_limit_now, jog_bits, output ready);
endinterface

interface sjvr_cfg_if import sjvr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/sjvr_axis_ramp.sv =====
// One axis on a tick: latch expiry, hold counter and velocity ramp or decay.
module sjvr_axis_ramp import sjvr_pkg::*; (
	input  ramp_cfg_t   cfg,
	input  axis_state_t cur,
	output axis_state_t nxt
);

	logic                     expire;
	logic [1:0]               pair;
	logic signed [CALC_W-1:0] v;
	logic signed [CALC_W-1:0] vmax;
	logic signed [CALC_W-1:0] acc;
	logic signed [CALC_W-1:0] dec;
	logic signed [CALC_W-1:0] v_nx;

	always_comb begin
		expire = (cur.count >= cfg.hold_ticks);
		pair   = expire ? 2'b00 : cur.pair;
		v      = CALC_W'(cur.speed);
		vmax   = $signed({{(CALC_W-LIMIT_W){1'b0}}, cfg.vmax});
		acc    = $signed({{(CALC_W-STEP_W){1'b0}}, cfg.accel});
		dec    = $signed({{(CALC_W-STEP_W){1'b0}}, cfg.decel});
		if (pair[0]) begin
			v_nx = (v < vmax - acc) ? v + acc : vmax;
		end else if (pair[1]) begin
			v_nx = (v > acc - vmax) ? v - acc : -vmax;
		end else if (v > dec) begin
			v_nx = v - dec;
		end else if (v < -dec) begin
			v_nx = v + dec;
		end else begin
			v_nx = '0;
		end
		nxt.count = expire ? cur.count : cur.count + HOLD_W'(1);
		nxt.pair  = pair;
		nxt.speed = speed_t'(v_nx[SPEED_W-1:0]);
	end

endmodule

// ===== rtl/core/six_axis_jog_velocity_ramp_unit.sv =====
// Top level of the six-axis jog velocity ramp unit.
//
// Channels: jog_in carries items (op 0 = key byte in key_code, op 1 = 1 ms tick);
// jog_out carries one result per item: six signed Q4.12 speed targets, the current
// speed limit and the twelve jog latch bits; cfg writes the seven ramp registers
// (index 0 accel_step .. 6 max_speed_ceiling), always ready; write them only while idle,
// which the block itself does not enforce. An item is taken into an input register;
// the state and the result register are updated from it once the result register is
// free, and the result is then offered on jog_out. One item is accepted every cycle
// while jog_out is taken every cycle; the input-to-result path is six parallel ramp units.
// Reset clears the jog latches, hold counters and speeds, sets the speed limit and
// all registers to their default values and empties both stages.
// When the receiver stalls, the result holds on jog_out, one more item may wait in
// the input register, and jog_in.ready drops until the result is taken.
module six_axis_jog_velocity_ramp_unit import sjvr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sjvr_in_if.sink     jog_in,
	sjvr_out_if.source  jog_out,
	sjvr_cfg_if.sink    cfg
);

	logic [STEP_W-1:0]  accel_q;
	logic [STEP_W-1:0]  decel_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [LIMIT_W-1:0] default_q;
	logic [STEP_W-1:0]  step_q;
	logic [LIMIT_W-1:0] floor_q;
	logic [LIMIT_W-1:0] ceiling_q;

	logic               valid_s1;
	logic               op_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               advance;

	logic [JOG_W-1:0]                latch_q;
	logic [AXES-1:0][HOLD_W-1:0]     cnt_q;
	speed_t [AXES-1:0]               speed_q;
	logic [LIMIT_W-1:0]              limit_q;

	logic [JOG_W-1:0]                latch_nx;
	logic [AXES-1:0][HOLD_W-1:0]     cnt_nx;
	speed_t [AXES-1:0]               speed_nx;
	logic [LIMIT_W-1:0]              limit_nx;
	speed_t [MAX_AXES-1:0]           speed_full;

	logic                            out_valid_q;
	speed_t [MAX_AXES-1:0]           out_speed_q;
	logic [LIMIT_W-1:0]              out_limit_q;
	logic [JOG_W-1:0]                out_jog_q;

	ramp_cfg_t                       ramp_cfg;
	axis_state_t [AXES-1:0]          ramp_cur;
	axis_state_t [AXES-1:0]          ramp_nxt;
	jog_key_t                        jog;
	logic [LIMIT_W:0]                lower_diff;
	logic [LIMIT_W:0]                raise_sum;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q   <= RST_ACCEL;
			decel_q   <= RST_DECEL;
			hold_q    <= RST_HOLD;
			default_q <= RST_DEFAULT;
			step_q    <= RST_STEP;
			floor_q   <= RST_FLOOR;
			ceiling_q <= RST_CEILING;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ACCEL:   accel_q   <= cfg.data;
				REG_DECEL:   decel_q   <= cfg.data;
				REG_HOLD:    hold_q    <= cfg.data[HOLD_W-1:0];
				REG_DEFAULT: default_q <= cfg.data;
				REG_STEP:    step_q    <= cfg.data;
				REG_FLOOR:   floor_q   <= cfg.data;
				REG_CEILING: ceiling_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || jog_out.ready);
	assign jog_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (jog_in.ready) begin
			valid_s1 <= jog_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (jog_in.valid && jog_in.ready) begin
			op_s1  <= jog_in.op;
			key_s1 <= jog_in.key_code;
		end
	end

	assign ramp_cfg.accel      = accel_q;
	assign ramp_cfg.decel      = decel_q;
	assign ramp_cfg.hold_ticks = hold_q;
	assign ramp_cfg.vmax       = limit_q;

	for (genvar g = 0; g < AXES; g++) begin : g_axis
		assign ramp_cur[g].count = cnt_q[g];
		assign ramp_cur[g].pair  = latch_q[2*g +: 2];
		assign ramp_cur[g].speed = speed_q[g];
		sjvr_axis_ramp u_ramp (
			.cfg (ramp_cfg),
			.cur (ramp_cur[g]),
			.nxt (ramp_nxt[g])
		);
	end

	always_comb begin
		jog        = jog_decode(key_s1);
		lower_diff = {1'b0, limit_q} - {1'b0, step_q};
		raise_sum  = {1'b0, limit_q} + {1'b0, step_q};
		latch_nx   = latch_q;
		cnt_nx     = cnt_q;
		speed_nx   = speed_q;
		limit_nx   = limit_q;
		if (op_s1 == OP_TICK) begin
			for (int a = 0; a < AXES; a++) begin
				latch_nx[2*a +: 2] = ramp_nxt[a].pair;
				cnt_nx[a]          = ramp_nxt[a].count;
				speed_nx[a]        = ramp_nxt[a].speed;
			end
		end else if (jog.hit) begin
			if (jog.bit_idx[3:1] < AXES) begin
				latch_nx[jog.bit_idx]   = 1'b1;
				cnt_nx[jog.bit_idx[3:1]] = '0;
			end
		end else begin
			unique case (key_s1)
				KEY_LOWER: begin
					if (limit_q > floor_q)
						limit_nx = lower_diff[LIMIT_W] ? '0 : lower_diff[LIMIT_W-1:0];
				end
				KEY_DEFAULT: limit_nx = default_q;
				KEY_RAISE: begin
					if (limit_q < ceiling_q)
						limit_nx = raise_sum[LIMIT_W] ? LIMIT_MAX : raise_sum[LIMIT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < MAX_AXES; g++) begin : g_full
		if (g < AXES) begin : g_on
			assign speed_full[g] = speed_nx[g];
		end else begin : g_off
			assign speed_full[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			cnt_q   <= '0;
			speed_q <= '0;
			limit_q <= RST_DEFAULT;
		end else if (advance) begin
			latch_q <= latch_nx;
			cnt_q   <= cnt_nx;
			speed_q <= speed_nx;
			limit_q <= limit_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (jog_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_speed_q <= speed_full;
			out_limit_q <= limit_nx;
			out_jog_q   <= latch_nx;
		end
	end

	assign jog_out.valid           = out_valid_q;
	assign jog_out.speed_axis0     = out_speed_q[0];
	assign jog_out.speed_axis1     = out_speed_q[1];
	assign jog_out.speed_axis2     = out_speed_q[2];
	assign jog_out.speed_axis3     = out_speed_q[3];
	assign jog_out.speed_axis4     = out_speed_q[4];
	assign jog_out.speed_axis5     = out_speed_q[5];
	assign jog_out.speed_limit_now = out_limit_q;
	assign jog_out.jog_bits        = out_jog_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		jog_in.valid && jog_in.ready |-> !valid_s1 || advance)
		else $error("item accepted over a held item");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without an item");

	a_key_keeps_speed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_KEY |=> $stable(speed_q))
		else $error("key item changed a speed");

	a_tick_keeps_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TICK |=> $stable(limit_q))
		else $error("tick item changed the speed limit");

endmodule
